FILE: hdl/thermocouple_frame_decode_average_assert.svh
// ---------------------------------------------------------------------------
// thermocouple frame decode average assertion macros
// shared concurrent assertion forms, reset-qualified
// ---------------------------------------------------------------------------
`ifndef THERMOCOUPLE_FRAME_DECODE_AVERAGE_ASSERT_SVH
`define THERMOCOUPLE_FRAME_DECODE_AVERAGE_ASSERT_SVH

// same-cycle implication
`define TFDA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TFDA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/tfda_pkg.sv
// ---------------------------------------------------------------------------
// tfda_pkg
// shared types and constants of the thermocouple frame decoder
// ---------------------------------------------------------------------------
package tfda_pkg;

  // taps per channel ring; must be a power of two (average is a shift)
  localparam int TAPS     = 8;
  localparam int CHANNELS = 4;

  localparam int CH_W      = 2;
  localparam int FRAME_W   = 32;
  localparam int PROBE_W   = 16;
  localparam int JUNC_W    = 12;
  localparam int FAULT_W   = 3;
  localparam int AVG_SHIFT = $clog2(TAPS);
  localparam int SLOT_W    = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int TOTAL_W   = PROBE_W + AVG_SHIFT;

  typedef struct packed {
    logic [CH_W-1:0]    channel;
    logic [FRAME_W-1:0] frame_word;
  } in_req_t;

  typedef struct packed {
    logic [CH_W-1:0]           channel_out;
    logic signed [PROBE_W-1:0] probe_tenths;
    logic signed [PROBE_W-1:0] averaged_tenths;
    logic signed [JUNC_W-1:0]  junction_tenths;
    logic [FAULT_W-1:0]        fault_bits;
  } out_res_t;

endpackage

FILE: hdl/tfda_if.sv
// ---------------------------------------------------------------------------
// tfda_if
// valid/ready channels carrying frame requests and decoded results
// ---------------------------------------------------------------------------
interface tfda_in_if;
  logic              valid;
  logic              ready;
  tfda_pkg::in_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface tfda_out_if;
  logic               valid;
  logic               ready;
  tfda_pkg::out_res_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: hdl/thermocouple_frame_decode_average.sv
// ---------------------------------------------------------------------------
// thermocouple_frame_decode_average
// converter frame decoder with a per-channel moving average of the probe
// ---------------------------------------------------------------------------
// usage
//   req_i: one request is a channel number and one raw 32-bit converter frame
//   res_o: one result per request, in order: channel echo, probe and
//     cold-junction temperatures in tenths of a degree, the moving average
//     of the probe over the last TAPS frames of that channel, fault bits
//   path: an accepted request is held in the input register, then in the
//     result register; the decode, tap swap and running-total update sit
//     between them
//   throughput: one request per cycle, any channel order, while res_o is not
//     held; the per-channel running total is updated in the same cycle its
//     tap is read, so back to back frames of one channel need no forwarding
//   stall: while res_o is held, the waiting request in the input register
//     stays put and req_i.ready drops only when both registers are full
//   reset: all taps, write slots and running totals clear to zero at once,
//     so the first frames average against zeros; requests still held in the
//     registers are dropped and none is invented across reset
// ---------------------------------------------------------------------------
`include "thermocouple_frame_decode_average_assert.svh"

module thermocouple_frame_decode_average (
  input logic          clk_i,
  input logic          rst_ni,
  tfda_in_if.sink      req_i,
  tfda_out_if.source   res_o
);

  // input register
  logic              s1_valid_q;
  tfda_pkg::in_req_t s1_q;
  logic              s1_move;

  // result register
  logic               out_valid_q;
  tfda_pkg::out_res_t out_q;
  tfda_pkg::out_res_t out_d;

  // per-channel state
  logic signed [tfda_pkg::PROBE_W-1:0] taps_q  [tfda_pkg::CHANNELS][tfda_pkg::TAPS];
  logic        [tfda_pkg::SLOT_W-1:0]  slot_q  [tfda_pkg::CHANNELS];
  logic signed [tfda_pkg::TOTAL_W-1:0] total_q [tfda_pkg::CHANNELS];

  // datapath
  logic signed [13:0]                  raw_probe;
  logic signed [16:0]                  probe_x5;
  logic signed [16:0]                  probe_half;
  logic signed [tfda_pkg::PROBE_W-1:0] probe;
  logic signed [11:0]                  raw_junc;
  logic signed [14:0]                  junc_x5;
  logic signed [14:0]                  junc_eighth;
  logic signed [tfda_pkg::PROBE_W-1:0] old_tap;
  logic signed [tfda_pkg::TOTAL_W-1:0] total_d;
  logic signed [tfda_pkg::TOTAL_W-1:0] total_bias;
  logic        [tfda_pkg::SLOT_W-1:0]  slot_cur;
  logic        [tfda_pkg::SLOT_W-1:0]  slot_nxt;
  logic                                ch_ok;
  logic                                upd;

  // --- handshake --------------------------------------------------------
  // result register empties or is taken -> input register may move on
  assign s1_move     = !out_valid_q || res_o.ready;
  assign req_i.ready = !s1_valid_q || s1_move;
  assign res_o.valid = out_valid_q;
  assign res_o.payload = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      s1_q <= req_i.payload;
    end
  end

  // --- decode -----------------------------------------------------------
  always_comb begin
    // probe: 0.25 deg lsb -> tenths is *5/2, truncated toward zero
    raw_probe  = $signed(s1_q.frame_word[31:18]);
    probe_x5   = ({{3{raw_probe[13]}}, raw_probe} <<< 2) + {{3{raw_probe[13]}}, raw_probe};
    probe_half = (probe_x5 + {16'd0, probe_x5[16]}) >>> 1;
    probe      = probe_half[tfda_pkg::PROBE_W-1:0];

    // cold junction: 0.0625 deg lsb -> tenths is *5/8, truncated toward zero
    raw_junc    = $signed(s1_q.frame_word[15:4]);
    junc_x5     = ({{3{raw_junc[11]}}, raw_junc} <<< 2) + {{3{raw_junc[11]}}, raw_junc};
    junc_eighth = (junc_x5 + (junc_x5[14] ? 15'sd7 : 15'sd0)) >>> 3;

    ch_ok    = (int'(s1_q.channel) < tfda_pkg::CHANNELS);
    upd      = s1_valid_q && s1_move && ch_ok;
    slot_cur = slot_q[s1_q.channel];
    slot_nxt = (int'(slot_cur) == tfda_pkg::TAPS - 1) ? '0 : slot_cur + 1'b1;

    // swap the oldest tap for the new probe value in the running total
    old_tap = taps_q[s1_q.channel][slot_cur];
    total_d = total_q[s1_q.channel]
            - {{tfda_pkg::AVG_SHIFT{old_tap[tfda_pkg::PROBE_W-1]}}, old_tap}
            + {{tfda_pkg::AVG_SHIFT{probe[tfda_pkg::PROBE_W-1]}}, probe};

    // divide by TAPS toward zero: bias negatives by TAPS-1, then shift
    total_bias = total_d + (total_d[tfda_pkg::TOTAL_W-1]
                 ? tfda_pkg::TOTAL_W'(tfda_pkg::TAPS - 1) : '0);

    out_d.channel_out     = s1_q.channel;
    out_d.probe_tenths    = probe;
    out_d.averaged_tenths = ch_ok
                            ? tfda_pkg::PROBE_W'(total_bias >>> tfda_pkg::AVG_SHIFT)
                            : probe;
    out_d.junction_tenths = junc_eighth[tfda_pkg::JUNC_W-1:0];
    out_d.fault_bits      = s1_q.frame_word[tfda_pkg::FAULT_W-1:0];
  end

  // --- per-channel ring state -------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < tfda_pkg::CHANNELS; c++) begin
        slot_q[c]  <= '0;
        total_q[c] <= '0;
        for (int t = 0; t < tfda_pkg::TAPS; t++) begin
          taps_q[c][t] <= '0;
        end
      end
    end else if (upd) begin
      slot_q[s1_q.channel]           <= slot_nxt;
      total_q[s1_q.channel]          <= total_d;
      taps_q[s1_q.channel][slot_cur] <= probe;
    end
  end

  // --- result register --------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move && s1_valid_q) begin
      out_q <= out_d;
    end
  end

  // --- assertions -------------------------------------------------------
  `TFDA_ASSERT_NXT(a_slot_advance, clk_i, rst_ni, upd,
    slot_q[$past(s1_q.channel)] == $past(slot_nxt), "write slot did not advance")
  `TFDA_ASSERT_IMP(a_result_from_s1, clk_i, rst_ni, $rose(out_valid_q),
    $past(s1_valid_q), "result appeared without a pending request")
  `TFDA_ASSERT_IMP(a_avg_range, clk_i, rst_ni, out_valid_q,
    (out_q.averaged_tenths >= -16'sd20480) && (out_q.averaged_tenths <= 16'sd20477),
    "average out of probe range")
  `TFDA_ASSERT_IMP(a_junc_range, clk_i, rst_ni, out_valid_q,
    (out_q.junction_tenths >= -12'sd1280) && (out_q.junction_tenths <= 12'sd1279),
    "junction temperature out of range")

endmodule

FILE: verif/testbench.sv
// ---------------------------------------------------------------------------
// thermocouple frame decode average testbench
// sends converter frames on all four channels through a bursty sender and
// checks every decoded result against an in-bench decoder and per-channel
// moving average, with a randomly stalling receiver and long output holds
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // no request may go this many cycles without a handshake on either side
  localparam int IDLE_LIMIT    = 4000;
  // long output hold, long enough for the block to fill and stall req_i
  localparam int LONG_HOLD     = 300;
  // settle time after the drain, before the final verdict
  localparam int SETTLE_CYCLES = 12;
  localparam int PRINT_CAP     = 40;

  logic clk_i;
  logic rst_ni;

  tfda_in_if  req_if ();
  tfda_out_if res_if ();

  thermocouple_frame_decode_average dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  // decoded results still owed by the block, oldest first
  tfda_pkg::out_res_t pending_results[$];

  // in-bench copy of the per-channel tap rings
  int tap_ring  [tfda_pkg::CHANNELS][tfda_pkg::TAPS];
  int ring_slot [tfda_pkg::CHANNELS];
  int ring_sum  [tfda_pkg::CHANNELS];

  int mismatch_count;
  int frames_sent;
  int results_checked;
  int holds_done;
  int burst_left;
  int channel_hits [tfda_pkg::CHANNELS];
  bit [7:0] fault_seen;
  bit hold_request;

  // ---------------------------------------------------------------------------
  // clock
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // decoder and moving average
  // ---------------------------------------------------------------------------
  function automatic void clear_rings();
    for (int c = 0; c < tfda_pkg::CHANNELS; c++) begin
      ring_slot[c] = 0;
      ring_sum[c]  = 0;
      for (int t = 0; t < tfda_pkg::TAPS; t++) tap_ring[c][t] = 0;
    end
  endfunction

  // probe: 14-bit quarter degrees -> tenths, junction: 12-bit sixteenths ->
  // tenths; both truncate toward zero, as does the average over the ring
  function automatic tfda_pkg::out_res_t decode_and_average(
      input logic [tfda_pkg::CH_W-1:0]    ch,
      input logic [tfda_pkg::FRAME_W-1:0] frame);
    tfda_pkg::out_res_t r;
    int raw_probe;
    int raw_junc;
    int probe;
    int junc;
    int avg;
    int slot;
    raw_probe = $signed(frame[31:18]);
    raw_junc  = $signed(frame[15:4]);
    probe     = raw_probe * 25 / 10;
    junc      = raw_junc * 625 / 1000;
    avg       = probe;
    // a channel outside the ring set passes the probe straight through
    if (int'(ch) < tfda_pkg::CHANNELS) begin
      slot = ring_slot[ch];
      ring_sum[ch]        = ring_sum[ch] - tap_ring[ch][slot] + probe;
      tap_ring[ch][slot]  = probe;
      ring_slot[ch]       = (slot + 1 >= tfda_pkg::TAPS) ? 0 : slot + 1;
      avg                 = ring_sum[ch] / tfda_pkg::TAPS;
    end
    r.channel_out     = ch;
    r.probe_tenths    = probe[tfda_pkg::PROBE_W-1:0];
    r.averaged_tenths = avg[tfda_pkg::PROBE_W-1:0];
    r.junction_tenths = junc[tfda_pkg::JUNC_W-1:0];
    r.fault_bits      = frame[tfda_pkg::FAULT_W-1:0];
    return r;
  endfunction

  // frame layout: probe 31..18, spare 17..16, junction 15..4, spare 3, faults 2..0
  function automatic logic [tfda_pkg::FRAME_W-1:0] pack_frame(input logic [13:0] probe,
                                                              input logic [11:0] junc,
                                                              input logic [2:0]  faults,
                                                              input logic [2:0]  spare);
    return {probe, spare[2:1], junc, spare[0], faults};
  endfunction

  function automatic logic [13:0] edge_probe();
    case ($urandom_range(0, 5))
      0:       return 14'h1FFF;
      1:       return 14'h2000;
      2:       return 14'h3FFF;
      3:       return 14'h0000;
      4:       return 14'h0001;
      default: return 14'($urandom);
    endcase
  endfunction

  function automatic logic [11:0] edge_junc();
    case ($urandom_range(0, 5))
      0:       return 12'h7FF;
      1:       return 12'h800;
      2:       return 12'hFFF;
      3:       return 12'h000;
      4:       return 12'h001;
      default: return 12'($urandom);
    endcase
  endfunction

  // half raw random frames, some pinned to the field limits, some near zero
  // where the truncation of negative averages matters
  function automatic logic [tfda_pkg::FRAME_W-1:0] random_frame();
    int near;
    near = $urandom_range(0, 40);
    case ($urandom_range(0, 3))
      0, 1:    return $urandom;
      2:       return pack_frame(edge_probe(), edge_junc(), 3'($urandom), 3'($urandom));
      default: return pack_frame(14'(near - 20), 12'(near - 20), 3'($urandom),
                                 3'($urandom));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------
  // bursts of random length, with random gaps at the start of each burst;
  // valid stays high within a burst, so it is never lowered and raised in
  // the same step
  task automatic send_frame(input logic [tfda_pkg::CH_W-1:0]    ch,
                            input logic [tfda_pkg::FRAME_W-1:0] frame);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        req_if.valid   <= 1'b0;
        req_if.payload <= '{channel: tfda_pkg::CH_W'($urandom), frame_word: $urandom};
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    req_if.valid   <= 1'b1;
    req_if.payload <= '{channel: ch, frame_word: frame};
    do @(posedge clk_i); while (!req_if.ready);
    pending_results.push_back(decode_and_average(ch, frame));
    frames_sent++;
    channel_hits[ch]++;
    fault_seen[frame[tfda_pkg::FAULT_W-1:0]] = 1'b1;
  endtask

  // sender goes quiet until every owed result has come back
  task automatic wait_until_drained();
    req_if.valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // result side: stall pattern with steady stretches and requested long holds
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int hold_left;
    int phase_left;
    bit steady;
    hold_left  = 0;
    phase_left = 0;
    steady     = 1'b0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LONG_HOLD;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        if (phase_left == 0) begin
          steady     = ($urandom_range(0, 3) == 0);
          phase_left = $urandom_range(20, 80);
        end
        phase_left--;
        res_if.ready <= steady ? 1'b1 : ($urandom_range(0, 2) != 0);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < PRINT_CAP)
      $display("[%0t] mismatch on %s: got %h, want %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin : check_results
    tfda_pkg::out_res_t got;
    tfda_pkg::out_res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = res_if.payload;
      if (pending_results.size() == 0) begin
        report_mismatch("unrequested result", 32'(got), 32'd0);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (got.channel_out !== want.channel_out)
          report_mismatch("channel_out", 32'(got.channel_out), 32'(want.channel_out));
        if (got.probe_tenths !== want.probe_tenths)
          report_mismatch("probe_tenths", 32'(got.probe_tenths), 32'(want.probe_tenths));
        if (got.averaged_tenths !== want.averaged_tenths)
          report_mismatch("averaged_tenths", 32'(got.averaged_tenths),
                          32'(want.averaged_tenths));
        if (got.junction_tenths !== want.junction_tenths)
          report_mismatch("junction_tenths", 32'(got.junction_tenths),
                          32'(want.junction_tenths));
        if (got.fault_bits !== want.fault_bits)
          report_mismatch("fault_bits", 32'(got.fault_bits), 32'(want.fault_bits));
      end
    end
  end

  // watchdog: cycles in a row with no handshake on either side
  always @(posedge clk_i) begin : watchdog
    int quiet_cycles;
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // all-zero and all-one frames, field limits, truncation of odd raw values
  task automatic test_field_extremes();
    send_frame(2'd0, 32'h0000_0000);
    send_frame(2'd3, 32'hFFFF_FFFF);
    send_frame(2'd1, pack_frame(14'h1FFF, 12'h7FF, 3'd0, 3'b000));
    send_frame(2'd2, pack_frame(14'h2000, 12'h800, 3'd0, 3'b111));
    // plus and minus one raw step on both temperatures
    send_frame(2'd0, pack_frame(14'h0001, 12'h001, 3'd0, 3'b010));
    send_frame(2'd3, pack_frame(14'h3FFF, 12'hFFF, 3'd0, 3'b101));
    // -7.5 and -9.375 tenths, both truncate toward zero
    send_frame(2'd1, pack_frame(14'h3FFD, 12'hFF1, 3'd0, 3'b100));
  endtask

  // every fault combination, decoded and averaged like a clean frame
  task automatic test_fault_bits();
    for (int f = 0; f < 8; f++)
      send_frame(2'd2, pack_frame(14'h0190, 12'h190, 3'(f), 3'($urandom)));
  endtask

  // wrap one ring, starting with small negative taps so the average
  // truncates toward zero rather than down
  task automatic test_ring_wrap();
    for (int i = 0; i < 3; i++) send_frame(2'd1, pack_frame(14'h3FFD, 12'h000, 3'd0, 3'd0));
    for (int i = 0; i < 4; i++) send_frame(2'd1, pack_frame(14'h1FFF, 12'h000, 3'd0, 3'd0));
    for (int i = 0; i < 2; i++) send_frame(2'd1, pack_frame(14'h3FFD, 12'h000, 3'd0, 3'd0));
  endtask

  task automatic test_random_traffic(input int count);
    for (int i = 0; i < count; i++) send_frame(tfda_pkg::CH_W'($urandom), random_frame());
  endtask

  // runs on one channel, each but possibly the last long enough to turn its ring over at least once
  task automatic test_single_channel_runs(input int count);
    logic [tfda_pkg::CH_W-1:0] ch;
    int run;
    while (count > 0) begin
      ch  = tfda_pkg::CH_W'($urandom);
      run = $urandom_range(10, 30);
      for (int i = 0; i < run && count > 0; i++, count--) send_frame(ch, random_frame());
    end
  endtask

  // receiver holds off while the sender keeps offering, so req_i stalls
  task automatic test_output_hold(input int count);
    hold_request = 1'b1;
    test_random_traffic(count);
  endtask

  // sender pauses until the pipeline is empty after each of two random runs
  task automatic test_drain_pause(input int count);
    test_random_traffic(count);
    wait_until_drained();
    test_random_traffic(count);
    wait_until_drained();
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    mismatch_count  = 0;
    frames_sent     = 0;
    results_checked = 0;
    holds_done      = 0;
    burst_left      = 0;
    fault_seen      = '0;
    hold_request    = 1'b0;
    for (int c = 0; c < tfda_pkg::CHANNELS; c++) channel_hits[c] = 0;
    clear_rings();

    rst_ni         <= 1'b0;
    req_if.valid   <= 1'b0;
    req_if.payload <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_field_extremes();
    test_fault_bits();
    test_ring_wrap();
    test_random_traffic(1150);
    test_output_hold(60);
    test_single_channel_runs(300);
    // ends with the sender idle and every result returned
    test_drain_pause(100);

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch("results never returned", 32'(pending_results.size()), 32'd0);

    $display("covered %0d frames (per channel %0d/%0d/%0d/%0d), %0d results checked",
             frames_sent, channel_hits[0], channel_hits[1], channel_hits[2],
             channel_hits[3], results_checked);
    $display("fault patterns seen %0d of 8, long output holds %0d, mismatches %0d",
             $countones(fault_seen), holds_done, mismatch_count);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
